>>> sv/bmp565_pkg.sv
// ---------------------------------------------------------------------------
// bmp565_pkg
// Shared types and constants for the BMP 24-bit to RGB565 stream decoder.
// ---------------------------------------------------------------------------
package bmp565_pkg;

    // Largest accepted width or height magnitude
    localparam int unsigned MAX_DIM = 4096;
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned ROWB_W  = 15;

    localparam logic [15:0] SIG_WIN   = 16'h4D42;
    localparam logic [15:0] PLANES_1  = 16'd1;
    localparam logic [15:0] DEPTH_24  = 16'd24;
    localparam logic [31:0] COMPR_RAW = 32'd0;

    // Header byte positions at which a field completes
    localparam logic [31:0] IDX_SIG     = 32'd1;
    localparam logic [31:0] IDX_OFFSET  = 32'd13;
    localparam logic [31:0] IDX_WIDTH   = 32'd21;
    localparam logic [31:0] IDX_HEIGHT  = 32'd25;
    localparam logic [31:0] IDX_PLANES  = 32'd27;
    localparam logic [31:0] IDX_DEPTH   = 32'd29;
    localparam logic [31:0] IDX_COMPR   = 32'd33;
    // Pixel data never starts before this byte
    localparam logic [31:0] HDR_END     = 32'd34;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ERR_SIGNATURE  = 3'd0,
        ERR_PLANES     = 3'd1,
        ERR_COMPRESSED = 3'd2,
        ERR_DEPTH      = 3'd3,
        ERR_SIZE       = 3'd4
    } err_t;

endpackage

>>> sv/bmp24_to_rgb565_stream_decoder_unit.sv
// One byte of the BMP file is taken per cycle; the block accepts a byte in every cycle in which
// its result register is empty or being drained, so the sustained rate is one byte per clock.
// A result (a pixel on the third byte of each blue, green, red triplet, or an error) appears
// in the cycle after the byte that causes it, held in a single output register; in_stall is high
// only while that register is full and out_stall is high. Header parsing, offset skipping,
// row padding and bottom-up row order are tracked by counters, and the start address of the
// first stored row is precomputed by a registered 13x13 multiply while the header is read.
// ---------------------------------------------------------------------------
// bmp24_to_rgb565_stream_decoder_unit
// Parses a 24-bit BMP byte stream and emits RGB565 pixels with image addresses, or header errors.
// ---------------------------------------------------------------------------
module bmp24_to_rgb565_stream_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  error_code,
    output logic [15:0] pixel_565,
    output logic [23:0] pixel_address,
    output logic        last_pixel
);

    localparam int unsigned DW = bmp565_pkg::DIM_W;
    localparam int unsigned AW = bmp565_pkg::ADDR_W;
    localparam int unsigned RW = bmp565_pkg::ROWB_W;

    // control state
    bmp565_pkg::phase_t phase_reg, phase_next;
    logic [31:0]   byte_count_reg, byte_count_next;
    logic [31:0]   header_shift_reg, header_shift_next;
    logic [31:0]   pixel_start_reg, pixel_start_next;
    logic [DW-1:0] image_width_reg, image_width_next;
    logic [DW-1:0] image_height_reg, image_height_next;
    logic          top_down_reg, top_down_next;
    logic          planes_bad_reg, planes_bad_next;
    logic          depth_bad_reg, depth_bad_next;
    logic          size_bad_reg, size_bad_next;
    logic [DW-1:0] column_reg, column_next;
    logic [DW-1:0] row_reg, row_next;
    logic [RW-1:0] row_byte_reg, row_byte_next;
    logic [1:0]    sub_reg, sub_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic          out_valid_reg;

    // payload and derived registers
    logic [7:0]    held_blue_reg, held_blue_next;
    logic [7:0]    held_green_reg, held_green_next;
    logic [DW-1:0] w_m1_reg;
    logic [DW-1:0] h_m1_reg;
    logic [RW-1:0] row_len3_reg;
    logic [RW-1:0] row_pad_reg;
    logic [AW-1:0] base_init_reg;
    logic          kind_reg;
    logic [2:0]    error_code_reg;
    logic [15:0]   pixel_565_reg;
    logic [23:0]   pixel_address_reg;
    logic          last_pixel_reg;

    // result of the current byte
    logic          emit;
    logic          kind_res;
    logic [2:0]    code_res;
    logic [15:0]   pix_res;
    logic [23:0]   addr_res;
    logic          last_res;

    logic               in_fire;
    bmp565_pkg::phase_t cur_phase;
    logic [31:0]        cur_count;
    logic [31:0]        cur_shift;
    logic [31:0]        shift_new;
    logic [31:0]        count_inc;
    logic               size_bad_cur;
    logic [31:0]        height_mag;
    logic               hdr_mode;
    logic               at_check;
    logic               sig_err;
    logic               chk_err;
    logic               hdr_zero;
    logic               hdr_skip;
    logic               begin_now;
    logic               in_row;
    logic               pix_emit;
    logic               is_last;
    logic               pix_done;
    logic [RW-1:0]      row_byte_inc;
    logic               row_wrap;
    logic [2*DW-1:0]    base_prod;

    assign in_fire      = in_valid && !in_stall;
    assign in_stall     = out_valid_reg && out_stall;

    // a start request restarts the parser on this very byte
    assign cur_phase    = start_req ? bmp565_pkg::PH_HEADER : phase_reg;
    assign cur_count    = start_req ? 32'd0 : byte_count_reg;
    assign cur_shift    = start_req ? 32'd0 : header_shift_reg;
    assign size_bad_cur = start_req ? 1'b0 : size_bad_reg;
    assign shift_new    = {data_byte, cur_shift[31:8]};
    assign count_inc    = cur_count + 32'd1;
    assign height_mag   = shift_new[31] ? (~shift_new + 32'd1) : shift_new;

    assign hdr_mode = (cur_phase == bmp565_pkg::PH_HEADER);
    assign at_check = hdr_mode && (cur_count == bmp565_pkg::IDX_COMPR);
    assign sig_err  = hdr_mode && (cur_count == bmp565_pkg::IDX_SIG)
                      && (shift_new[31:16] != bmp565_pkg::SIG_WIN);
    assign chk_err  = at_check && (planes_bad_reg || (shift_new != bmp565_pkg::COMPR_RAW)
                      || depth_bad_reg || size_bad_cur);
    assign hdr_zero = at_check && !chk_err
                      && ((image_width_reg == '0) || (image_height_reg == '0));
    assign hdr_skip = at_check && !chk_err && !hdr_zero
                      && (pixel_start_reg > bmp565_pkg::HDR_END);
    assign begin_now = (at_check && !chk_err && !hdr_zero && !hdr_skip)
                       || ((cur_phase == bmp565_pkg::PH_SKIP) && (count_inc == pixel_start_reg));

    assign in_row       = row_byte_reg < row_len3_reg;
    assign pix_emit     = (cur_phase == bmp565_pkg::PH_PIXELS) && in_row && (sub_reg == 2'd2);
    assign is_last      = (row_reg == h_m1_reg) && (column_reg == w_m1_reg);
    assign pix_done     = pix_emit && is_last;
    assign row_byte_inc = row_byte_reg + RW'(1);
    assign row_wrap     = row_byte_inc >= row_pad_reg;

    assign base_prod    = (2*DW)'(h_m1_reg) * (2*DW)'(image_width_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            if (sig_err || chk_err || hdr_zero || pix_done)
                phase_next = bmp565_pkg::PH_DONE;
            else if (hdr_skip)
                phase_next = bmp565_pkg::PH_SKIP;
            else if (begin_now)
                phase_next = bmp565_pkg::PH_PIXELS;
            else if (start_req)
                phase_next = bmp565_pkg::PH_HEADER;
        end
    end

    // result of the current byte
    always_comb
    begin
        emit     = 1'b0;
        kind_res = bmp565_pkg::KIND_PIXEL;
        code_res = 3'd0;
        pix_res  = 16'd0;
        addr_res = 24'd0;
        last_res = 1'b0;
        if (sig_err)
        begin
            emit     = 1'b1;
            kind_res = bmp565_pkg::KIND_ERROR;
            code_res = bmp565_pkg::ERR_SIGNATURE;
        end
        else if (chk_err)
        begin
            emit     = 1'b1;
            kind_res = bmp565_pkg::KIND_ERROR;
            if (planes_bad_reg)
                code_res = bmp565_pkg::ERR_PLANES;
            else if (shift_new != bmp565_pkg::COMPR_RAW)
                code_res = bmp565_pkg::ERR_COMPRESSED;
            else if (depth_bad_reg)
                code_res = bmp565_pkg::ERR_DEPTH;
            else
                code_res = bmp565_pkg::ERR_SIZE;
        end
        else if (pix_emit)
        begin
            emit     = 1'b1;
            pix_res  = {data_byte[7:3], held_green_reg[7:2], held_blue_reg[7:3]};
            addr_res = row_base_reg + AW'(column_reg);
            last_res = is_last;
        end
    end

    // datapath and counters
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        header_shift_next = header_shift_reg;
        pixel_start_next  = pixel_start_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        top_down_next     = top_down_reg;
        planes_bad_next   = planes_bad_reg;
        depth_bad_next    = depth_bad_reg;
        size_bad_next     = size_bad_reg;
        column_next       = column_reg;
        row_next          = row_reg;
        row_byte_next     = row_byte_reg;
        sub_next          = sub_reg;
        row_base_next     = row_base_reg;
        held_blue_next    = held_blue_reg;
        held_green_next   = held_green_reg;
        if (in_fire)
        begin
            if (start_req)
            begin
                pixel_start_next  = '0;
                image_width_next  = '0;
                image_height_next = '0;
                top_down_next     = 1'b0;
                planes_bad_next   = 1'b0;
                depth_bad_next    = 1'b0;
                size_bad_next     = 1'b0;
            end
            case (cur_phase)
                bmp565_pkg::PH_HEADER:
                begin
                    byte_count_next   = count_inc;
                    header_shift_next = shift_new;
                    if (cur_count == bmp565_pkg::IDX_OFFSET)
                        pixel_start_next = shift_new;
                    if (cur_count == bmp565_pkg::IDX_WIDTH)
                    begin
                        if (shift_new > 32'(bmp565_pkg::MAX_DIM))
                            size_bad_next = 1'b1;
                        else
                            image_width_next = shift_new[DW-1:0];
                    end
                    if (cur_count == bmp565_pkg::IDX_HEIGHT)
                    begin
                        top_down_next = shift_new[31];
                        if (height_mag > 32'(bmp565_pkg::MAX_DIM))
                            size_bad_next = 1'b1;
                        else
                            image_height_next = height_mag[DW-1:0];
                    end
                    if (cur_count == bmp565_pkg::IDX_PLANES)
                        planes_bad_next = shift_new[31:16] != bmp565_pkg::PLANES_1;
                    if (cur_count == bmp565_pkg::IDX_DEPTH)
                        depth_bad_next = shift_new[31:16] != bmp565_pkg::DEPTH_24;
                end
                bmp565_pkg::PH_SKIP:
                begin
                    byte_count_next = count_inc;
                end
                bmp565_pkg::PH_PIXELS:
                begin
                    byte_count_next = count_inc;
                    if (in_row)
                    begin
                        case (sub_reg)
                            2'd0:
                            begin
                                held_blue_next = data_byte;
                                sub_next       = 2'd1;
                            end
                            2'd1:
                            begin
                                held_green_next = data_byte;
                                sub_next        = 2'd2;
                            end
                            default:
                            begin
                                column_next = column_reg + DW'(1);
                                sub_next    = 2'd0;
                            end
                        endcase
                    end
                    // the final pixel ends the image; the row counters freeze
                    if (!pix_done)
                    begin
                        row_byte_next = row_byte_inc;
                        if (row_wrap)
                        begin
                            row_byte_next = '0;
                            column_next   = '0;
                            sub_next      = 2'd0;
                            row_next      = row_reg + DW'(1);
                            row_base_next = top_down_reg ? row_base_reg + AW'(image_width_reg)
                                                         : row_base_reg - AW'(image_width_reg);
                        end
                    end
                end
                default:
                begin
                    byte_count_next = byte_count_reg;
                end
            endcase
            if (begin_now)
            begin
                column_next   = '0;
                row_next      = '0;
                row_byte_next = '0;
                sub_next      = 2'd0;
                row_base_next = top_down_reg ? '0 : base_init_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= bmp565_pkg::PH_IDLE;
            byte_count_reg   <= '0;
            header_shift_reg <= '0;
            pixel_start_reg  <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            top_down_reg     <= 1'b0;
            planes_bad_reg   <= 1'b0;
            depth_bad_reg    <= 1'b0;
            size_bad_reg     <= 1'b0;
            column_reg       <= '0;
            row_reg          <= '0;
            row_byte_reg     <= '0;
            sub_reg          <= 2'd0;
            row_base_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            header_shift_reg <= header_shift_next;
            pixel_start_reg  <= pixel_start_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            top_down_reg     <= top_down_next;
            planes_bad_reg   <= planes_bad_next;
            depth_bad_reg    <= depth_bad_next;
            size_bad_reg     <= size_bad_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            row_byte_reg     <= row_byte_next;
            sub_reg          <= sub_next;
            row_base_reg     <= row_base_next;
            if (in_fire)
                out_valid_reg <= emit;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Row geometry is registered from the header sizes, row_pad_reg and base_init_reg from other
    // registered values; it is first read at the end of the header, after the sizes are complete.
    always_ff @(posedge clk)
    begin
        held_blue_reg  <= held_blue_next;
        held_green_reg <= held_green_next;
        w_m1_reg       <= image_width_reg - DW'(1);
        h_m1_reg       <= image_height_reg - DW'(1);
        row_len3_reg   <= {image_width_reg, 1'b0} + RW'(image_width_reg);
        row_pad_reg    <= (row_len3_reg + RW'(3)) & ~RW'(3);
        base_init_reg  <= base_prod[AW-1:0];
        if (in_fire && emit)
        begin
            kind_reg          <= kind_res;
            error_code_reg    <= code_res;
            pixel_565_reg     <= pix_res;
            pixel_address_reg <= addr_res;
            last_pixel_reg    <= last_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign error_code    = error_code_reg;
    assign pixel_565     = pixel_565_reg;
    assign pixel_address = pixel_address_reg;
    assign last_pixel    = last_pixel_reg;

    a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && emit && (kind_res == bmp565_pkg::KIND_ERROR)
        |=> phase_reg == bmp565_pkg::PH_DONE)
        else $error("error result did not stop the parser");

    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && emit && last_res |=> phase_reg == bmp565_pkg::PH_DONE)
        else $error("last pixel did not end the image");

    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bmp565_pkg::PH_PIXELS |-> column_reg <= image_width_reg)
        else $error("column ran past the image width");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty result register");

endmodule

>>> tb/tb_bmp24_to_rgb565_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bmp24_to_rgb565_stream_decoder_unit
// Feeds BMP byte streams to the decoder and checks each pixel and error
// result against a cycle-free model of the parser kept in the testbench.
// Directed files cover header errors, error priority, zero and oversized
// dimensions, early and late pixel offsets, both row orders, padding and
// restarts. Random files follow: mostly well formed, some cut short or
// broken, with loose bytes in between. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_bmp24_to_rgb565_stream_decoder_unit;

    localparam int unsigned TOTAL_BYTES = 1950;
    localparam int unsigned LONG_HOLD   = 300;

    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic       drain;
    } bmp_byte_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  code;
        logic [15:0] rgb;
        logic [23:0] addr;
        logic        last;
    } bmp_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        start_req = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [2:0]  error_code;
    logic [15:0] pixel_565;
    logic [23:0] pixel_address;
    logic        last_pixel;

    bmp_byte_t   pending_bytes[$];
    bmp_result_t expected_results[$];

    int unsigned total_bytes;
    int unsigned bytes_accepted;
    int unsigned file_bytes;
    int unsigned files_started;
    int unsigned pixels_checked;
    int unsigned errors_checked;
    int unsigned mismatches;
    int unsigned hold_left;
    bit          long_hold_done;

    // decoder model state
    logic [31:0]        bytes_seen;
    logic [31:0]        hdr_window;
    logic [31:0]        data_offset;
    logic [31:0]        img_w;
    logic [31:0]        img_h;
    logic               top_down;
    bmp565_pkg::phase_t dec_phase;
    logic [31:0]        col;
    logic [31:0]        line;
    logic [31:0]        line_byte;
    logic [7:0]         blue_hold;
    logic [7:0]         green_hold;
    logic [23:0]        line_base;
    logic               planes_wrong;
    logic               depth_wrong;
    logic               dims_wrong;

    bmp24_to_rgb565_stream_decoder_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .start_req     (start_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .error_code    (error_code),
        .pixel_565     (pixel_565),
        .pixel_address (pixel_address),
        .last_pixel    (last_pixel)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] padded_row(input logic [31:0] w);
        return (3 * w + 32'd3) & ~32'd3;
    endfunction

    function automatic int unsigned image_body(input logic [31:0] offset, input logic [31:0] w,
                                               input logic [31:0] h_mag);
        int unsigned skip;
        skip = (offset > bmp565_pkg::HDR_END) ? offset - bmp565_pkg::HDR_END : 0;
        return skip + padded_row(w) * h_mag;
    endfunction

    // idle percentages by stimulus progress: sender light, then receiver light, then none
    function automatic int unsigned sender_gap_pct();
        if (bytes_accepted < total_bytes / 3)
            return 23;
        else if (bytes_accepted < 2 * total_bytes / 3)
            return 48;
        return 0;
    endfunction

    function automatic int unsigned receiver_gap_pct();
        if (bytes_accepted < total_bytes / 3)
            return 48;
        else if (bytes_accepted < 2 * total_bytes / 3)
            return 23;
        return 0;
    endfunction

    task automatic clear_decoder();
        bytes_seen   = 0;
        hdr_window   = 0;
        data_offset  = 0;
        img_w        = 0;
        img_h        = 0;
        top_down     = 1'b0;
        dec_phase    = bmp565_pkg::PH_IDLE;
        col          = 0;
        line         = 0;
        line_byte    = 0;
        blue_hold    = 8'd0;
        green_hold   = 8'd0;
        line_base    = 24'd0;
        planes_wrong = 1'b0;
        depth_wrong  = 1'b0;
        dims_wrong   = 1'b0;
    endtask

    task automatic place_row();
        logic [31:0] target;
        logic [31:0] prod;
        target    = top_down ? line : img_h - 32'd1 - line;
        prod      = target * img_w;
        line_base = prod[23:0];
    endtask

    task automatic open_pixels();
        dec_phase = bmp565_pkg::PH_PIXELS;
        col       = 0;
        line      = 0;
        line_byte = 0;
        place_row();
    endtask

    task automatic report_error(input bmp565_pkg::err_t code);
        bmp_result_t res;
        res       = '0;
        res.kind  = bmp565_pkg::KIND_ERROR;
        res.code  = code;
        expected_results.push_back(res);
        dec_phase = bmp565_pkg::PH_DONE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic first);
        logic [31:0] idx;
        logic [31:0] mag;
        logic [31:0] sub;
        logic        at_end;
        bmp_result_t res;
        if (first)
        begin
            clear_decoder();
            dec_phase = bmp565_pkg::PH_HEADER;
            files_started++;
        end
        case (dec_phase)
            bmp565_pkg::PH_HEADER:
            begin
                idx        = bytes_seen;
                hdr_window = {b, hdr_window[31:8]};
                bytes_seen++;
                case (idx)
                    bmp565_pkg::IDX_SIG:
                        if (hdr_window[31:16] != bmp565_pkg::SIG_WIN)
                            report_error(bmp565_pkg::ERR_SIGNATURE);
                    bmp565_pkg::IDX_OFFSET:
                        data_offset = hdr_window;
                    bmp565_pkg::IDX_WIDTH:
                        if (hdr_window > bmp565_pkg::MAX_DIM)
                            dims_wrong = 1'b1;
                        else
                            img_w = hdr_window;
                    bmp565_pkg::IDX_HEIGHT:
                    begin
                        top_down = hdr_window[31];
                        mag      = top_down ? ~hdr_window + 32'd1 : hdr_window;
                        if (mag > bmp565_pkg::MAX_DIM)
                            dims_wrong = 1'b1;
                        else
                            img_h = mag;
                    end
                    bmp565_pkg::IDX_PLANES:
                        planes_wrong = (hdr_window[31:16] != bmp565_pkg::PLANES_1);
                    bmp565_pkg::IDX_DEPTH:
                        depth_wrong = (hdr_window[31:16] != bmp565_pkg::DEPTH_24);
                    bmp565_pkg::IDX_COMPR:
                    begin
                        if (planes_wrong)
                            report_error(bmp565_pkg::ERR_PLANES);
                        else if (hdr_window != bmp565_pkg::COMPR_RAW)
                            report_error(bmp565_pkg::ERR_COMPRESSED);
                        else if (depth_wrong)
                            report_error(bmp565_pkg::ERR_DEPTH);
                        else if (dims_wrong)
                            report_error(bmp565_pkg::ERR_SIZE);
                        else if (img_w == 0 || img_h == 0)
                            dec_phase = bmp565_pkg::PH_DONE;
                        else if (data_offset > bmp565_pkg::HDR_END)
                            dec_phase = bmp565_pkg::PH_SKIP;
                        else
                            open_pixels();
                    end
                    default: ;
                endcase
            end
            bmp565_pkg::PH_SKIP:
            begin
                bytes_seen++;
                if (bytes_seen == data_offset)
                    open_pixels();
            end
            bmp565_pkg::PH_PIXELS:
            begin
                bytes_seen++;
                if (line_byte < 3 * img_w)
                begin
                    sub = line_byte - 3 * col;
                    if (sub == 0)
                        blue_hold = b;
                    else if (sub == 1)
                        green_hold = b;
                    else
                    begin
                        at_end   = (line == img_h - 32'd1) && (col == img_w - 32'd1);
                        res      = '0;
                        res.kind = bmp565_pkg::KIND_PIXEL;
                        res.rgb  = {b[7:3], green_hold[7:2], blue_hold[7:3]};
                        res.addr = line_base + col[23:0];
                        res.last = at_end;
                        expected_results.push_back(res);
                        col++;
                        if (at_end)
                            dec_phase = bmp565_pkg::PH_DONE;
                    end
                end
                // past the final pixel nothing advances
                if (dec_phase == bmp565_pkg::PH_PIXELS)
                begin
                    line_byte++;
                    if (line_byte >= padded_row(img_w))
                    begin
                        line_byte = 0;
                        col       = 0;
                        line++;
                        place_row();
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic first, input bit drain);
        bmp_byte_t item;
        item.b     = b;
        item.first = first;
        item.drain = drain;
        pending_bytes.push_back(item);
    endtask

    // Build one file; cut < 0 sends header and body whole, else at most the first cut bytes.
    task automatic queue_bmp(input logic [15:0] sig, input logic [31:0] offset,
                             input logic [31:0] width, input logic [31:0] height,
                             input logic [15:0] planes, input logic [15:0] depth,
                             input logic [31:0] compr, input int unsigned body_len,
                             input int cut, input bit drain);
        logic [7:0]  hdr [34];
        int unsigned send_len;
        for (int i = 0; i < 34; i++)
            hdr[i] = 8'($urandom_range(255));
        {hdr[1], hdr[0]}                   = sig;
        {hdr[13], hdr[12], hdr[11], hdr[10]} = offset;
        {hdr[21], hdr[20], hdr[19], hdr[18]} = width;
        {hdr[25], hdr[24], hdr[23], hdr[22]} = height;
        {hdr[27], hdr[26]}                 = planes;
        {hdr[29], hdr[28]}                 = depth;
        {hdr[33], hdr[32], hdr[31], hdr[30]} = compr;
        send_len = 34 + body_len;
        if (cut >= 0 && cut < send_len)
            send_len = cut;
        for (int unsigned i = 0; i < send_len; i++)
            queue_byte((i < 34) ? hdr[i] : 8'($urandom_range(255)), i == 0, drain && i == 0);
        file_bytes += send_len;
    endtask

    task automatic queue_loose(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    // driver: hold a stalled request, otherwise offer the next byte or idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'd0;
            start_req <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                decode_byte(data_byte, start_req);
                bytes_accepted++;
            end
            if (pending_bytes.size() != 0
                && !(pending_bytes[0].drain && expected_results.size() != 0)
                && $urandom_range(99) >= sender_gap_pct())
            begin
                in_valid  <= 1'b1;
                data_byte <= pending_bytes[0].b;
                start_req <= pending_bytes[0].first;
                void'(pending_bytes.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: check accepted results
    bmp_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0d code %0d",
                         $time, kind, error_code);
                $display("%0t:   pixel 0x%0h addr 0x%0h last %0d",
                         $time, pixel_565, pixel_address, last_pixel);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, kind);
                check_field("error_code", want.code, error_code);
                check_field("pixel_565", want.rgb, pixel_565);
                check_field("pixel_address", want.addr, pixel_address);
                check_field("last_pixel", want.last, last_pixel);
                if (want.kind == bmp565_pkg::KIND_ERROR)
                    errors_checked++;
                else
                    pixels_checked++;
            end
        end
    end

    // receiver: random stall, plus one long hold-off so the output fills and backs up the input
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!long_hold_done && pixels_checked >= 120)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            out_stall      <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_gap_pct());
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still expected", expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int unsigned      pick;
        logic [31:0]      w;
        logic [31:0]      h;
        logic [31:0]      hm;
        logic [31:0]      offset;
        logic [31:0]      cm;
        logic [15:0]      sig;
        logic [15:0]      pl;
        logic [15:0]      dp;
        bmp565_pkg::err_t defect;
        clear_decoder();

        // loose bytes before any start are dropped
        queue_byte(8'h42, 1'b0, 1'b0);
        queue_byte(8'h4D, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        // 1x1 bottom-up with skipped gap before pixels, then padding and trailer
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd54, 32'd1, 32'd1, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                  image_body(32'd54, 32'd1, 32'd1), -1, 1'b0);
        queue_loose(3);
        // top-down with an offset inside the header
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd0, 32'd3, 32'hFFFF_FFFE, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                  image_body(32'd0, 32'd3, 32'd2), -1, 1'b0);
        // offset right at the header end, padded rows
        queue_bmp(bmp565_pkg::SIG_WIN, bmp565_pkg::HDR_END, 32'd5, 32'd3, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                  image_body(bmp565_pkg::HDR_END, 32'd5, 32'd3), -1, 1'b1);
        queue_bmp(16'h4D43, 32'd54, 32'd2, 32'd2, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW, 6, -1, 1'b0);
        // several defects at once: planes wins
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd54, 32'd5000, 32'd2, 16'd2, 16'd32, 32'd1,
                  4, -1, 1'b0);
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd54, 32'd2, 32'd2, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, 32'hFFFF_FFFF, 4, -1, 1'b0);
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd54, 32'd2, 32'd2, bmp565_pkg::PLANES_1,
                  16'hFFFF, bmp565_pkg::COMPR_RAW, 4, -1, 1'b0);
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd54, bmp565_pkg::MAX_DIM + 1, 32'd2,
                  bmp565_pkg::PLANES_1, bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                  4, -1, 1'b0);
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd54, 32'd2, 32'h8000_0000, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW, 4, -1, 1'b0);
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd54, 32'd2, 32'hFFFF_EFFF, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW, 4, -1, 1'b0);
        // zero width, then zero height: nothing comes out
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd34, 32'd0, 32'd3, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW, 12, -1, 1'b0);
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd34, 32'd3, 32'd0, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW, 12, -1, 1'b0);
        // largest images, cut short by the next start
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd40, bmp565_pkg::MAX_DIM, bmp565_pkg::MAX_DIM,
                  bmp565_pkg::PLANES_1, bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                  image_body(32'd40, bmp565_pkg::MAX_DIM, bmp565_pkg::MAX_DIM),
                  34 + 6 + 150, 1'b0);
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd34, bmp565_pkg::MAX_DIM,
                  ~bmp565_pkg::MAX_DIM + 32'd1, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                  image_body(32'd34, bmp565_pkg::MAX_DIM, bmp565_pkg::MAX_DIM),
                  34 + 120, 1'b0);
        // restart in the middle of a header
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd34, 32'd2, 32'd2, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW, 16, 20, 1'b0);
        queue_bmp(bmp565_pkg::SIG_WIN, 32'd36, 32'd1, 32'd1, bmp565_pkg::PLANES_1,
                  bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                  image_body(32'd36, 32'd1, 32'd1), -1, 1'b0);

        file_bytes = 0;
        while (pending_bytes.size() < TOTAL_BYTES)
        begin
            pick = $urandom_range(99);
            w    = $urandom_range(1, 9);
            hm   = $urandom_range(1, 6);
            h    = $urandom_range(1) ? ~hm + 32'd1 : hm;
            case ($urandom_range(2))
                0: offset = $urandom_range(33);
                1: offset = bmp565_pkg::HDR_END;
                default: offset = $urandom_range(35, 70);
            endcase
            if (pick < 70)
            begin
                queue_bmp(bmp565_pkg::SIG_WIN, offset, w, h, bmp565_pkg::PLANES_1,
                          bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                          image_body(offset, w, hm), -1,
                          file_bytes == 0 || $urandom_range(7) == 0);
                queue_loose($urandom_range(4));
            end
            else if (pick < 80)
                queue_bmp(bmp565_pkg::SIG_WIN, offset, w, h, bmp565_pkg::PLANES_1,
                          bmp565_pkg::DEPTH_24, bmp565_pkg::COMPR_RAW,
                          image_body(offset, w, hm),
                          $urandom_range(1, 33 + image_body(offset, w, hm)), 1'b0);
            else if (pick < 92)
            begin
                sig    = bmp565_pkg::SIG_WIN;
                pl     = bmp565_pkg::PLANES_1;
                dp     = bmp565_pkg::DEPTH_24;
                cm     = bmp565_pkg::COMPR_RAW;
                defect = bmp565_pkg::err_t'($urandom_range(4));
                case (defect)
                    bmp565_pkg::ERR_SIGNATURE:
                        sig = bmp565_pkg::SIG_WIN ^ 16'($urandom_range(1, 65535));
                    bmp565_pkg::ERR_PLANES:
                        pl = bmp565_pkg::PLANES_1 ^ 16'($urandom_range(1, 65535));
                    bmp565_pkg::ERR_COMPRESSED:
                        cm = $urandom() | 32'd1;
                    bmp565_pkg::ERR_DEPTH:
                        dp = bmp565_pkg::DEPTH_24 ^ 16'($urandom_range(1, 65535));
                    default:
                        if ($urandom_range(1))
                            w = $urandom_range(bmp565_pkg::MAX_DIM + 1, 32'hFFFF_FFFF);
                        else
                        begin
                            hm = $urandom_range(bmp565_pkg::MAX_DIM + 1, 32'h8000_0000);
                            h  = $urandom_range(1) ? ~hm + 32'd1 : hm;
                        end
                endcase
                queue_bmp(sig, offset, w, h, pl, dp, cm, $urandom_range(8), -1, 1'b0);
            end
            else
                queue_loose($urandom_range(2, 6));
        end
        total_bytes = pending_bytes.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d files; checked %0d pixels and %0d header errors",
                 bytes_accepted, files_started, pixels_checked, errors_checked);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
